@@ hw/rtl/smdc_pkg.sv @@
package smdc_pkg;

	// Register map: one 32-bit word per register.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_DC_ALPHA    = 2'd0;
	localparam logic [1:0] REG_OUTPUT_GAIN = 2'd1;
	localparam logic [1:0] REG_INPUT_SHIFT = 2'd2;

	localparam logic [15:0] DC_ALPHA_RST    = 16'd65208;
	localparam logic [15:0] OUTPUT_GAIN_RST = 16'd1280;
	localparam logic [4:0]  INPUT_SHIFT_RST = 5'd14;

	// Shared multiplier: signed 25-bit operand times a 16-bit unsigned coefficient.
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_SHIFT,
		ST_ACC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_YSAT,
		ST_FILT,
		ST_GAIN,
		ST_GSAT
	} state_t;

	typedef enum logic [1:0] {
		SEL_ACC_LO,
		SEL_ACC_HI,
		SEL_GAIN
	} mul_sel_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0]        b;
	} mul_req_t;

endpackage

@@ hw/rtl/smdc_mul.sv @@
module smdc_mul import smdc_pkg::*; (
	input  logic                      clk,
	input  mul_req_t                  req,
	output logic signed [MUL_P_W-1:0] prod
);

	logic signed [MUL_B_W:0] b_ext;

	// The coefficient is unsigned, so it gets a zero sign bit.
	assign b_ext = $signed({1'b0, req.b});

	// Registered product, loaded only when the sequencer asks for it.
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod <= req.a * b_ext;
		end
	end

endmodule

@@ hw/rtl/stereo_mix_dc_block_gain_core.sv @@
// Stereo to mono DC-blocking gain stage.
//
// Input channel (in_valid / in_ready): one stereo pair, left_sample and
// right_sample, signed 32 bits. The pair is averaged, shifted right by
// input_shift, wrapped to 16 bits, passed through a one-pole DC blocker
// (coefficient dc_alpha, Q0.16), truncated and saturated, then scaled by
// output_gain (Q8.8) and saturated again.
// Output channel (out_valid / out_ready): one signed 16-bit mono_sample for
// each request taken.
// A new request is taken only in the idle state, once the previous sample
// has been loaded toward the output register. A sequencer steps each sample
// through one shared 25x16 multiplier, which is used three times per sample.
// The result sits in an output register, so a new request is taken while a
// finished sample waits. If the receiver stalls and that register is still
// full, the final step holds until it drains.
// Configuration: APB-style port, registers at byte addresses 0 (dc_alpha),
// 4 (output_gain) and 8 (input_shift). Write only while idle.
// Reset clears the filter history and loads the default register values.
module stereo_mix_dc_block_gain_core import smdc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       left_sample,
	input  logic signed [31:0]       right_sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [15:0]       mono_sample
);

	state_t state_q, state_d;
	mul_sel_t mul_sel;
	logic mul_en;
	mul_req_t mul_req;
	logic signed [MUL_P_W-1:0] mul_p;

	logic [15:0] dc_alpha_q;
	logic [15:0] output_gain_q;
	logic [4:0]  input_shift_q;

	logic signed [31:0] left_q, right_q, avg_q;
	logic signed [15:0] x_q, prev_x_q, filt_q;
	logic signed [40:0] acc_q;
	logic signed [57:0] prod_q;
	logic signed [39:0] prev_y_q;
	logic               out_load;

	logic signed [32:0] sum33, avg33;
	logic signed [31:0] shifted;
	logic signed [16:0] diff;
	logic signed [57:0] prod_rnd;
	logic signed [41:0] y_full;
	logic signed [39:0] y_sat;
	logic signed [39:0] y_rnd;
	logic signed [23:0] f_full;
	logic signed [15:0] f_sat;
	logic signed [32:0] g_prod, g_rnd;
	logic signed [24:0] g_full;
	logic signed [15:0] g_sat;

	assign pready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_alpha_q    <= DC_ALPHA_RST;
			output_gain_q <= OUTPUT_GAIN_RST;
			input_shift_q <= INPUT_SHIFT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_DC_ALPHA:    dc_alpha_q    <= pwdata[15:0];
				REG_OUTPUT_GAIN: output_gain_q <= pwdata[15:0];
				REG_INPUT_SHIFT: input_shift_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			REG_DC_ALPHA:    prdata = {16'b0, dc_alpha_q};
			REG_OUTPUT_GAIN: prdata = {16'b0, output_gain_q};
			REG_INPUT_SHIFT: prdata = {27'b0, input_shift_q};
			default:         prdata = '0;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_AVG;
			ST_AVG:    state_d = ST_SHIFT;
			ST_SHIFT:  state_d = ST_ACC;
			ST_ACC:    state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SUM;
			ST_SUM:    state_d = ST_YSAT;
			ST_YSAT:   state_d = ST_FILT;
			ST_FILT:   state_d = ST_GAIN;
			ST_GAIN:   state_d = ST_GSAT;
			ST_GSAT:   if (!out_valid || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		mul_en   = 1'b0;
		mul_sel  = SEL_ACC_LO;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_MUL_LO: begin
				mul_en  = 1'b1;
				mul_sel = SEL_ACC_LO;
			end
			ST_MUL_HI: begin
				mul_en  = 1'b1;
				mul_sel = SEL_ACC_HI;
			end
			ST_GAIN: begin
				mul_en  = 1'b1;
				mul_sel = SEL_GAIN;
			end
			ST_GSAT:   out_load = !out_valid || out_ready;
			default: ;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_req.en = mul_en;
		case (mul_sel)
			SEL_ACC_LO: begin
				mul_req.a = $signed({1'b0, acc_q[23:0]});
				mul_req.b = dc_alpha_q;
			end
			SEL_ACC_HI: begin
				mul_req.a = $signed({{8{acc_q[40]}}, acc_q[40:24]});
				mul_req.b = dc_alpha_q;
			end
			default: begin
				mul_req.a = $signed({{9{filt_q[15]}}, filt_q});
				mul_req.b = output_gain_q;
			end
		endcase
	end

	smdc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_p)
	);

	// Average with truncation toward zero, then shift and wrap to 16 bits.
	assign sum33   = $signed({left_q[31], left_q}) + $signed({right_q[31], right_q});
	assign avg33   = (sum33 + $signed({32'b0, sum33[32]})) >>> 1;
	assign shifted = avg_q >>> input_shift_q;

	// Filter accumulator input: new difference scaled into the Q.16 domain.
	assign diff = $signed({x_q[15], x_q}) - $signed({prev_x_q[15], prev_x_q});

	// Product divided by 2^16 toward zero, saturated to 40 bits.
	assign prod_rnd = prod_q + $signed({42'b0, {16{prod_q[57]}}});
	assign y_full   = prod_rnd[57:16];
	always_comb begin
		if (y_full[41:39] == 3'b000 || y_full[41:39] == 3'b111) begin
			y_sat = y_full[39:0];
		end else if (y_full[41]) begin
			y_sat = {1'b1, 39'b0};
		end else begin
			y_sat = {1'b0, {39{1'b1}}};
		end
	end

	// Integer part of the filter output, toward zero, saturated to 16 bits.
	assign y_rnd  = prev_y_q + $signed({24'b0, {16{prev_y_q[39]}}});
	assign f_full = y_rnd[39:16];
	always_comb begin
		if (f_full[23:15] == 9'h000 || f_full[23:15] == 9'h1FF) begin
			f_sat = f_full[15:0];
		end else if (f_full[23]) begin
			f_sat = 16'sh8000;
		end else begin
			f_sat = 16'sh7FFF;
		end
	end

	// Gain product divided by 256 toward zero, saturated to 16 bits.
	assign g_prod = mul_p[32:0];
	assign g_rnd  = g_prod + $signed({25'b0, {8{g_prod[32]}}});
	assign g_full = g_rnd[32:8];
	always_comb begin
		if (g_full[24:15] == 10'h000 || g_full[24:15] == 10'h3FF) begin
			g_sat = g_full[15:0];
		end else if (g_full[24]) begin
			g_sat = 16'sh8000;
		end else begin
			g_sat = 16'sh7FFF;
		end
	end

	// Datapath registers, loaded step by step.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					left_q  <= left_sample;
					right_q <= right_sample;
				end
			end
			ST_AVG:    avg_q  <= avg33[31:0];
			ST_SHIFT:  x_q    <= shifted[15:0];
			ST_ACC:    acc_q  <= $signed({{prev_y_q[39]}, prev_y_q})
				+ $signed({{8{diff[16]}}, diff, 16'b0});
			ST_MUL_HI: prod_q <= $signed({{16{mul_p[41]}}, mul_p});
			ST_SUM:    prod_q <= prod_q + $signed({mul_p[33:0], 24'b0});
			ST_FILT:   filt_q <= f_sat;
			default: ;
		endcase
	end

	// Filter history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (state_q == ST_YSAT) begin
			prev_x_q <= x_q;
			prev_y_q <= y_sat;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mono_sample <= g_sat;
		end
	end

endmodule

@@ hw/rtl/smdc_checker.sv @@
module smdc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] mono_sample
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mono_sample))
	else $error("mono_sample changed while stalled");

	// A result only leaves when it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
	else $error("out_valid dropped without a handshake");

	// After a request is taken, the block does not take the next one straight away.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
	else $error("new request taken while a sample is in work");

	// A result never appears right after a request is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
	else $error("result appeared too early");

endmodule

bind stereo_mix_dc_block_gain_core smdc_checker u_smdc_checker (.*);
